>>> hdl/pgalloc_pkg.sv
// shared types, constants and helpers for the page allocator
`timescale 1ns / 1ps
package pgalloc_pkg;

  // region and store geometry
  localparam int MAX_PAGES  = 32768;
  localparam int IDX_W      = $clog2(MAX_PAGES);
  localparam int DEPTH_W    = IDX_W + 1;
  localparam int CNT_W      = 16;
  localparam int PAGE_SHIFT = 12;
  localparam int ADDR_W     = 32;
  localparam int PAGE_W     = ADDR_W - PAGE_SHIFT;
  localparam int PCOUNT_W   = 16;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  // operation codes
  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_ADDREF = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_OOM       = 3'd1,
    ST_BAD_ADDR  = 3'd2,
    ST_NOT_REF   = 3'd3,
    ST_SATURATED = 3'd4
  } status_t;

  // controller states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_POP,
    S_RMW
  } state_t;

  // register map indexes
  localparam logic REG_FIRST_PAGE = 1'b0;
  localparam logic REG_PAGE_COUNT = 1'b1;

  // configuration registers as seen by the controller
  typedef struct packed {
    logic [PAGE_W-1:0]   first_page;
    logic [PCOUNT_W-1:0] page_count;
  } cfg_t;

  // refcount memory request
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [CNT_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } rc_req_t;

  // free stack memory request
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } stk_req_t;

  // page count clipped to the store depth
  function automatic logic [DEPTH_W-1:0] eff_count(input logic [PCOUNT_W-1:0] cnt);
    logic [DEPTH_W-1:0] lim;
    lim = DEPTH_W'(MAX_PAGES);
    if (DEPTH_W'(cnt) > lim) begin
      return lim;
    end
    return DEPTH_W'(cnt);
  endfunction

  // byte address of a region index
  function automatic logic [ADDR_W-1:0] page_addr(input logic [PAGE_W-1:0] first,
                                                  input logic [IDX_W-1:0]  idx);
    logic [PAGE_W-1:0] pg;
    pg = first + PAGE_W'(idx);
    return {pg, {PAGE_SHIFT{1'b0}}};
  endfunction

endpackage

>>> hdl/pgalloc_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module pgalloc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/pgalloc_regs.sv
// apb configuration registers for the page allocator
`timescale 1ns / 1ps
module pgalloc_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pgalloc_pkg::PADDR_W-1:0] paddr,
  input  logic [pgalloc_pkg::PDATA_W-1:0] pwdata,
  output logic [pgalloc_pkg::PDATA_W-1:0] prdata,
  output logic                            pready,
  output pgalloc_pkg::cfg_t               cfg
);
  import pgalloc_pkg::*;

  logic [PAGE_W-1:0]   first_page;
  logic [PCOUNT_W-1:0] page_count;
  logic                wr_en;
  logic                reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      first_page <= '0;
      page_count <= '0;
    end else if (wr_en) begin
      if (reg_sel == REG_FIRST_PAGE) begin
        first_page <= pwdata[PAGE_W-1:0];
      end else begin
        page_count <= pwdata[PCOUNT_W-1:0];
      end
    end
  end

  // read mux
  always_comb begin
    if (reg_sel == REG_FIRST_PAGE) begin
      prdata = PDATA_W'(first_page);
    end else begin
      prdata = PDATA_W'(page_count);
    end
  end

  assign cfg.first_page = first_page;
  assign cfg.page_count = page_count;

endmodule

>>> hdl/pgalloc_ctrl.sv
// operation sequencer: lookup, refcount read-modify-write, stack push and pop
`timescale 1ns / 1ps
module pgalloc_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  pgalloc_pkg::cfg_t                   cfg,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          opcode,
  input  logic [pgalloc_pkg::ADDR_W-1:0]      address,
  output logic                                done,
  output logic [pgalloc_pkg::ADDR_W-1:0]      page_address,
  output logic [pgalloc_pkg::CNT_W-1:0]       ref_count,
  output logic [2:0]                          status,
  output pgalloc_pkg::rc_req_t                rc_req,
  input  logic [pgalloc_pkg::CNT_W-1:0]       rc_rdata,
  output pgalloc_pkg::stk_req_t               stk_req,
  input  logic [pgalloc_pkg::IDX_W-1:0]       stk_rdata
);
  import pgalloc_pkg::*;

  state_t              state, state_next;
  op_t                 op_q, op_q_next;
  logic [ADDR_W-1:0]   addr_q, addr_q_next;
  logic [IDX_W-1:0]    idx_q, idx_q_next;
  logic [DEPTH_W-1:0]  stack_depth, stack_depth_next;
  logic [DEPTH_W-1:0]  fresh_used, fresh_used_next;
  logic [IDX_W-1:0]    clr_cnt, clr_cnt_next;
  logic                done_next;
  logic [ADDR_W-1:0]   page_address_next;
  logic [CNT_W-1:0]    ref_count_next;
  status_t             status_q, status_next;

  logic [DEPTH_W-1:0]  eff;
  logic [DEPTH_W-1:0]  depth_dec;
  logic [DEPTH_W-1:0]  fresh_rem;
  logic                fresh_avail;
  logic [PAGE_W:0]     page_diff;
  logic                lk_ok;
  logic [IDX_W-1:0]    lk_idx;
  logic [CNT_W-1:0]    cnt_dec;
  logic [CNT_W-1:0]    cnt_inc;

  assign busy   = (state != S_IDLE);
  assign status = status_q;

  // region bounds and address lookup
  assign eff         = eff_count(cfg.page_count);
  assign depth_dec   = stack_depth - 1'b1;
  assign fresh_avail = (fresh_used < eff);
  assign fresh_rem   = eff - 1'b1 - fresh_used;
  assign page_diff   = {1'b0, addr_q[ADDR_W-1:PAGE_SHIFT]} - {1'b0, cfg.first_page};
  assign lk_ok       = (addr_q[PAGE_SHIFT-1:0] == '0) && !page_diff[PAGE_W] &&
                       (page_diff[PAGE_W-1:0] < PAGE_W'(eff));
  assign lk_idx      = page_diff[IDX_W-1:0];
  assign cnt_dec     = rc_rdata - 1'b1;
  assign cnt_inc     = rc_rdata + 1'b1;

  // state and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_cnt     <= '0;
      stack_depth <= '0;
      fresh_used  <= '0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      clr_cnt     <= clr_cnt_next;
      stack_depth <= stack_depth_next;
      fresh_used  <= fresh_used_next;
      done        <= done_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_q         <= op_q_next;
    addr_q       <= addr_q_next;
    idx_q        <= idx_q_next;
    page_address <= page_address_next;
    ref_count    <= ref_count_next;
    status_q     <= status_next;
  end

  // next state, memory requests and results
  always_comb begin
    state_next        = state;
    op_q_next         = op_q;
    addr_q_next       = addr_q;
    idx_q_next        = idx_q;
    stack_depth_next  = stack_depth;
    fresh_used_next   = fresh_used;
    clr_cnt_next      = clr_cnt;
    done_next         = 1'b0;
    page_address_next = page_address;
    ref_count_next    = ref_count;
    status_next       = status_q;
    rc_req.we         = 1'b0;
    rc_req.waddr      = idx_q;
    rc_req.wdata      = '0;
    rc_req.raddr      = lk_idx;
    stk_req.we        = 1'b0;
    stk_req.waddr     = stack_depth[IDX_W-1:0];
    stk_req.wdata     = idx_q;
    stk_req.raddr     = depth_dec[IDX_W-1:0];

    unique case (state)
      // clearing pass over the refcount store
      S_CLEAR: begin
        rc_req.we    = 1'b1;
        rc_req.waddr = clr_cnt;
        rc_req.wdata = '0;
        clr_cnt_next = clr_cnt + 1'b1;
        if (&clr_cnt) begin
          state_next = S_IDLE;
        end
      end

      // wait for a command
      S_IDLE: begin
        if (start) begin
          op_q_next   = op_t'(opcode);
          addr_q_next = address;
          state_next  = S_DECODE;
        end
      end

      // pick a page or look the address up
      S_DECODE: begin
        if (op_q == OP_ALLOC) begin
          if (stack_depth != '0) begin
            stack_depth_next = depth_dec;
            state_next       = S_POP;
          end else if (fresh_avail) begin
            rc_req.we         = 1'b1;
            rc_req.waddr      = fresh_rem[IDX_W-1:0];
            rc_req.wdata      = CNT_W'(1);
            fresh_used_next   = fresh_used + 1'b1;
            done_next         = 1'b1;
            page_address_next = page_addr(cfg.first_page, fresh_rem[IDX_W-1:0]);
            ref_count_next    = CNT_W'(1);
            status_next       = ST_OK;
            state_next        = S_IDLE;
          end else begin
            done_next         = 1'b1;
            page_address_next = '0;
            ref_count_next    = '0;
            status_next       = ST_OOM;
            state_next        = S_IDLE;
          end
        end else if (!lk_ok) begin
          done_next         = 1'b1;
          page_address_next = '0;
          ref_count_next    = '0;
          status_next       = ST_BAD_ADDR;
          state_next        = S_IDLE;
        end else begin
          idx_q_next = lk_idx;
          state_next = S_RMW;
        end
      end

      // popped index is back from the stack
      S_POP: begin
        rc_req.we         = 1'b1;
        rc_req.waddr      = stk_rdata;
        rc_req.wdata      = CNT_W'(1);
        done_next         = 1'b1;
        page_address_next = page_addr(cfg.first_page, stk_rdata);
        ref_count_next    = CNT_W'(1);
        status_next       = ST_OK;
        state_next        = S_IDLE;
      end

      // refcount is back: modify and write
      S_RMW: begin
        done_next         = 1'b1;
        page_address_next = '0;
        status_next       = ST_OK;
        state_next        = S_IDLE;
        unique case (op_q)
          OP_FREE: begin
            if (rc_rdata == '0) begin
              ref_count_next = '0;
              status_next    = ST_NOT_REF;
            end else begin
              rc_req.we      = 1'b1;
              rc_req.wdata   = cnt_dec;
              ref_count_next = cnt_dec;
              // last reference gone: push unless the stack is full
              if ((cnt_dec == '0) && !stack_depth[DEPTH_W-1]) begin
                stk_req.we       = 1'b1;
                stack_depth_next = stack_depth + 1'b1;
              end
            end
          end
          OP_ADDREF: begin
            if (&rc_rdata) begin
              ref_count_next = rc_rdata;
              status_next    = ST_SATURATED;
            end else begin
              rc_req.we      = 1'b1;
              rc_req.wdata   = cnt_inc;
              ref_count_next = cnt_inc;
            end
          end
          OP_READ, OP_ALLOC: begin
            ref_count_next = rc_rdata;
          end
        endcase
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/page_allocator_with_refcount_unit.sv
// top level of the lifo page allocator with reference counts
`timescale 1ns / 1ps
// Page allocator over a region of 4 KiB pages with a 16-bit reference count
// per page. A command is taken when start is high and busy is low; its
// result appears with done high for exactly one cycle and must be captured
// then. Allocate from fresh pages, out-of-memory and bad-address commands
// finish in the decode state; allocate from the free stack and all free,
// add-reference and read-count commands on valid pages go on to the pop or
// read-modify-write state to wait for the registered read of the refcount
// or free stack memory ahead of the write-back. After reset the refcount
// memory is cleared one entry per cycle, all 32768 entries, with busy high;
// configuration writes are taken throughout. Configure only while idle.
module page_allocator_with_refcount_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      opcode,
  input  logic [pgalloc_pkg::ADDR_W-1:0]  address,
  output logic                            done,
  output logic [pgalloc_pkg::ADDR_W-1:0]  page_address,
  output logic [pgalloc_pkg::CNT_W-1:0]   ref_count,
  output logic [2:0]                      status,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pgalloc_pkg::PADDR_W-1:0] paddr,
  input  logic [pgalloc_pkg::PDATA_W-1:0] pwdata,
  output logic [pgalloc_pkg::PDATA_W-1:0] prdata,
  output logic                            pready
);
  import pgalloc_pkg::*;

  cfg_t             cfg;
  rc_req_t          rc_req;
  stk_req_t         stk_req;
  logic [CNT_W-1:0] rc_rdata;
  logic [IDX_W-1:0] stk_rdata;

  // configuration registers
  pgalloc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // command sequencer
  pgalloc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .address      (address),
    .done         (done),
    .page_address (page_address),
    .ref_count    (ref_count),
    .status       (status),
    .rc_req       (rc_req),
    .rc_rdata     (rc_rdata),
    .stk_req      (stk_req),
    .stk_rdata    (stk_rdata)
  );

  // per-page reference counts
  pgalloc_ram #(
    .WIDTH (CNT_W),
    .DEPTH (MAX_PAGES)
  ) u_rc_ram (
    .clk   (clk),
    .we    (rc_req.we),
    .waddr (rc_req.waddr),
    .wdata (rc_req.wdata),
    .raddr (rc_req.raddr),
    .rdata (rc_rdata)
  );

  // lifo of freed page indexes
  pgalloc_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_PAGES)
  ) u_stk_ram (
    .clk   (clk),
    .we    (stk_req.we),
    .waddr (stk_req.waddr),
    .wdata (stk_req.wdata),
    .raddr (stk_req.raddr),
    .rdata (stk_rdata)
  );

endmodule
